// ===== hw/rtl/crcfc_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
package crcfc_pkg;

  // CRC-32, reflected form.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // Frame layout: header byte, two length bytes, payload, four CRC bytes.
  localparam logic [7:0]  FRAME_HEADER   = 8'h00;
  localparam int unsigned POS_W          = 17;
  localparam int unsigned TOTAL_W        = POS_W + 1;
  localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = TOTAL_W'(7);
  localparam logic [POS_W-1:0]   POS_MAX        = {POS_W{1'b1}};

  // Status codes of a frame.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT        = 3'd1;
  localparam logic [2:0] ST_HEADER       = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN     = 3'd3;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd4;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd5;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Default depth of the result queue (a power of two, at least 4).
  localparam int unsigned QUEUE_DEPTH = 4;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic       run_last;
  } result_t;

  // Up to two results that one input item pushes into the queue.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  // One byte into the reflected CRC register, unrolled over the eight bits.
  function automatic logic [31:0] crc_add_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/crcfc_ctrl.sv =====
// Input register, frame state and per-byte result generation of the frame checker.
module crcfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                space_ok,
  output crcfc_pkg::push_t    push
);

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Frame state.
  logic [crcfc_pkg::POS_W-1:0] pos_r;
  logic [crcfc_pkg::POS_W-1:0] pos_nxt;
  logic [7:0]                  hdr_r;
  logic [7:0]                  hdr_nxt;
  logic [15:0]                 len_r;
  logic [15:0]                 len_nxt;
  logic [31:0]                 crc_r;
  logic [31:0]                 crc_nxt;
  logic [31:0]                 rcv_r;
  logic [31:0]                 rcv_nxt;

  logic                          go;
  logic                          is_payload;
  logic                          in_window;
  logic [crcfc_pkg::POS_W-1:0]   offset;
  logic [crcfc_pkg::TOTAL_W-1:0] total;
  logic [2:0]                    st;
  crcfc_pkg::result_t            res_pay;
  crcfc_pkg::result_t            res_stat;

  // The registered item moves on when the queue has room for two results.
  assign go       = in_valid_r && space_ok;
  assign in_ready = !in_valid_r || space_ok;

  assign offset    = pos_r - crcfc_pkg::POS_W'(3);
  assign in_window = (pos_r >= crcfc_pkg::POS_W'(3)) && (offset < {1'b0, len_r});

  // Store the byte by its position in the buffer.
  always_comb begin
    hdr_nxt    = hdr_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    rcv_nxt    = rcv_r;
    is_payload = 1'b0;
    priority if (pos_r == crcfc_pkg::POS_W'(0)) begin
      hdr_nxt = in_byte_r;
    end else if (pos_r == crcfc_pkg::POS_W'(1)) begin
      len_nxt = {in_byte_r, len_r[7:0]};
    end else if (pos_r == crcfc_pkg::POS_W'(2)) begin
      len_nxt = {len_r[15:8], in_byte_r};
    end else if (in_window) begin
      crc_nxt    = crcfc_pkg::crc_add_byte(crc_r, in_byte_r);
      is_payload = 1'b1;
    end else begin
      rcv_nxt = {rcv_r[23:0], in_byte_r};
    end
  end

  // Position counter saturates on very long buffers.
  assign pos_nxt = (pos_r == crcfc_pkg::POS_MAX) ? pos_r : pos_r + crcfc_pkg::POS_W'(1);
  assign total   = {1'b0, pos_r} + crcfc_pkg::TOTAL_W'(1);

  // Frame checks, first failure wins; they see the state after this byte.
  always_comb begin
    priority if (total <= crcfc_pkg::FRAME_OVERHEAD) begin
      st = crcfc_pkg::ST_SHORT;
    end else if (hdr_nxt != crcfc_pkg::FRAME_HEADER) begin
      st = crcfc_pkg::ST_HEADER;
    end else if (len_nxt == 16'd0) begin
      st = crcfc_pkg::ST_ZERO_LEN;
    end else if (total != crcfc_pkg::FRAME_OVERHEAD + {2'b00, len_nxt}) begin
      st = crcfc_pkg::ST_LEN_MISMATCH;
    end else if (~crc_nxt != rcv_nxt) begin
      st = crcfc_pkg::ST_CRC_MISMATCH;
    end else begin
      st = crcfc_pkg::ST_OK;
    end
  end

  // Results of this item: an optional payload byte, then an optional status.
  always_comb begin
    res_pay.kind          = crcfc_pkg::KIND_PAYLOAD;
    res_pay.payload_byte  = in_byte_r;
    res_pay.status        = crcfc_pkg::ST_OK;
    res_pay.run_last      = !in_last_r;
    res_stat.kind         = crcfc_pkg::KIND_STATUS;
    res_stat.payload_byte = 8'd0;
    res_stat.status       = st;
    res_stat.run_last     = 1'b1;
    push.push0 = go && (is_payload || in_last_r);
    push.push1 = go && is_payload && in_last_r;
    push.res0  = is_payload ? res_pay : res_stat;
    push.res1  = res_stat;
  end

  // Input register and frame state; a flagged byte returns the state to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      pos_r      <= '0;
      hdr_r      <= 8'd0;
      len_r      <= 16'd0;
      crc_r      <= crcfc_pkg::CRC_ONES;
      rcv_r      <= 32'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (go) begin
        if (in_last_r) begin
          pos_r <= '0;
          hdr_r <= 8'd0;
          len_r <= 16'd0;
          crc_r <= crcfc_pkg::CRC_ONES;
          rcv_r <= 32'd0;
        end else begin
          pos_r <= pos_nxt;
          hdr_r <= hdr_nxt;
          len_r <= len_nxt;
          crc_r <= crc_nxt;
          rcv_r <= rcv_nxt;
        end
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

endmodule

// ===== hw/rtl/crcfc_queue.sv =====
// Result queue that takes up to two results a cycle and gives one a cycle while out_ready is high.
module crcfc_queue #(
  parameter int unsigned DEPTH = crcfc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  crcfc_pkg::push_t   push,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output crcfc_pkg::result_t out_res
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crcfc_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_p1;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               pop;

  // Room for two results, judged on the registered count alone.
  assign space_ok  = cnt_r <= CNT_W'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.push0) + PTR_W'(push.push1);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage: first result at the tail, second one behind it.
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue count above depth");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second result pushed without a first");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> space_ok)
    else $error("result pushed without room in the queue");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.push0) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("queue count did not drop after a pop");
`endif

endmodule

// ===== hw/rtl/crc32_frame_checker_top.sv =====
// Top level of the length-prefixed frame checker with CRC-32.
//
//   channel | handshake           | item fields
//   --------+---------------------+-------------------------------------------
//   input   | in_valid/in_ready   | in_byte, in_last
//   result  | out_valid/out_ready | out_kind, out_payload_byte, out_status,
//           |                     | out_run_last
//
// One input item is taken per cycle while the queue has room; its results pass the input register and the queue.
// The queue takes up to two results a cycle; a flagged payload byte gives two.
// The output port gives one result a cycle while out_ready is high, which sets the sustained rate.
// Reset is synchronous and returns the frame state and the queue to empty.
// Input stalls only while the result queue cannot take two more results.
module crc32_frame_checker_top #(
  parameter int unsigned QUEUE_DEPTH = crcfc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [2:0] out_status,
  output logic       out_run_last
);

  crcfc_pkg::push_t   push;
  crcfc_pkg::result_t out_res;
  logic               space_ok;

  // Frame state and result generation.
  crcfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .space_ok (space_ok),
    .push     (push)
  );

  // Result queue toward the output channel.
  crcfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_status       = out_res.status;
  assign out_run_last     = out_res.run_last;

endmodule

// ===== dv/frame_result_checker.sv =====
// Checker for the CRC-32 frame checker: predicts results from accepted bytes and compares them.
module frame_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_kind,
  input  logic [7:0] out_payload_byte,
  input  logic [2:0] out_status,
  input  logic       out_run_last,
  output int         fail_count,
  output int         results_due,
  output int         results_seen,
  output int         frames_ok
);

  // A payload result carries an all-zero status field.
  localparam logic [2:0] NO_STATUS    = 3'd0;
  localparam int         REPORT_LIMIT = 10;

  // Predicted frame state.
  logic [crcfc_pkg::POS_W-1:0] pos_q;
  logic [7:0]                  hdr_q;
  logic [15:0]                 len_q;
  logic [31:0]                 crc_q;
  logic [31:0]                 rx_crc_q;

  // Results owed by the block, oldest first.
  crcfc_pkg::result_t frame_results_due[$];
  crcfc_pkg::result_t seen_result;

  initial begin
    fail_count   = 0;
    results_due  = 0;
    results_seen = 0;
    frames_ok    = 0;
  end

  // Reflected CRC-32, one byte folded in bit by bit.
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ crcfc_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic clear_frame();
    pos_q    = '0;
    hdr_q    = 8'd0;
    len_q    = 16'd0;
    crc_q    = crcfc_pkg::CRC_ONES;
    rx_crc_q = 32'd0;
  endtask

  // Take one accepted byte, update the frame state and queue what it causes.
  task automatic fold_in_byte(input logic [7:0] b, input logic flagged);
    logic [crcfc_pkg::POS_W-1:0]   p;
    logic [crcfc_pkg::POS_W-1:0]   len_ext;
    logic [crcfc_pkg::TOTAL_W-1:0] total;
    crcfc_pkg::result_t            r;
    p       = pos_q;
    len_ext = {1'b0, len_q};
    r       = '0;
    if (p == crcfc_pkg::POS_W'(0)) begin
      hdr_q = b;
    end else if (p == crcfc_pkg::POS_W'(1)) begin
      len_q[15:8] = b;
    end else if (p == crcfc_pkg::POS_W'(2)) begin
      len_q[7:0] = b;
    end else if ((p - crcfc_pkg::POS_W'(3)) < len_ext) begin
      // Payload window: the byte goes out at once, whatever the checks say later.
      crc_q          = crc_fold_byte(crc_q, b);
      r.kind         = crcfc_pkg::KIND_PAYLOAD;
      r.payload_byte = b;
      r.status       = NO_STATUS;
      r.run_last     = !flagged;
      frame_results_due.push_back(r);
    end else begin
      rx_crc_q = {rx_crc_q[23:0], b};
    end
    if (pos_q != crcfc_pkg::POS_MAX) pos_q = pos_q + crcfc_pkg::POS_W'(1);

    // The final byte of a buffer closes it with a status.
    if (flagged) begin
      len_ext        = {1'b0, len_q};
      total          = {1'b0, p} + crcfc_pkg::TOTAL_W'(1);
      r.kind         = crcfc_pkg::KIND_STATUS;
      r.payload_byte = 8'd0;
      r.run_last     = 1'b1;
      if (total <= crcfc_pkg::FRAME_OVERHEAD) begin
        r.status = crcfc_pkg::ST_SHORT;
      end else if (hdr_q != crcfc_pkg::FRAME_HEADER) begin
        r.status = crcfc_pkg::ST_HEADER;
      end else if (len_q == 16'd0) begin
        r.status = crcfc_pkg::ST_ZERO_LEN;
      end else if (total != crcfc_pkg::FRAME_OVERHEAD + {1'b0, len_ext}) begin
        r.status = crcfc_pkg::ST_LEN_MISMATCH;
      end else if (~crc_q != rx_crc_q) begin
        r.status = crcfc_pkg::ST_CRC_MISMATCH;
      end else begin
        r.status = crcfc_pkg::ST_OK;
        frames_ok++;
      end
      frame_results_due.push_back(r);
      clear_frame();
    end
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, what);
  endtask

  // Compare one accepted result with the oldest one owed.
  task automatic check_result(input crcfc_pkg::result_t got);
    crcfc_pkg::result_t want;
    if (frame_results_due.size() == 0) begin
      note_failure($sformatf("result with none due: kind %0d byte %02h status %0d last %0d",
                             got.kind, got.payload_byte, got.status, got.run_last));
    end else begin
      want = frame_results_due.pop_front();
      results_seen++;
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.status !== want.status || got.run_last !== want.run_last) begin
        note_failure($sformatf({"expected kind %0d byte %02h status %0d last %0d, ",
                                "got kind %0d byte %02h status %0d last %0d"},
                               want.kind, want.payload_byte, want.status, want.run_last,
                               got.kind, got.payload_byte, got.status, got.run_last));
      end
    end
  endtask

  // Watch both channels at every rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      frame_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen_result.kind         = out_kind;
        seen_result.payload_byte = out_payload_byte;
        seen_result.status       = out_status;
        seen_result.run_last     = out_run_last;
        check_result(seen_result);
      end
      if (in_valid && in_ready) fold_in_byte(in_byte, in_last);
    end
    results_due = frame_results_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the CRC-32 frame checker: builds buffers, drives channels, gives the verdict.
module tb_top;

  localparam int RANDOM_BYTES = 1950;
  localparam int IDLE_PCT     = 32;
  localparam int HOLD_CYCLES  = 300;

  typedef enum int {
    BUF_GOOD, BUF_BAD_CRC, BUF_BAD_HEADER, BUF_ZERO_LEN, BUF_LEN_OFF, BUF_SHORT, BUF_NOISE
  } buf_kind_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_payload_byte;
  logic [2:0] out_status;
  logic       out_run_last;

  int fail_count;
  int results_due;
  int results_seen;
  int frames_ok;

  // Shared pacing controls: calm turns idling off on both sides, hold_req asks for a long stall.
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int bytes_sent   = 0;
  int buffers_sent = 0;

  logic [7:0] buf_q[$];
  logic [7:0] pay_q[$];

  crc32_frame_checker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_run_last     (out_run_last)
  );

  frame_result_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_run_last     (out_run_last),
    .fail_count       (fail_count),
    .results_due      (results_due),
    .results_seen     (results_seen),
    .frames_ok        (frames_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one byte, with a random gap first, and wait until it is taken.
  task automatic offer_byte(input logic [7:0] b, input logic flagged);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= flagged;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) offer_byte(buf_q[i], i == buf_q.size() - 1);
    buffers_sent++;
  endtask

  task automatic random_bytes(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(8'($urandom_range(255)));
  endtask

  // Frame the payload: header, big-endian length, payload, big-endian CRC.
  task automatic wrap_payload(input logic [7:0] hdr, input logic [15:0] len_field);
    logic [31:0] c;
    c = crcfc_pkg::CRC_ONES;
    buf_q.delete();
    buf_q.push_back(hdr);
    buf_q.push_back(len_field[15:8]);
    buf_q.push_back(len_field[7:0]);
    foreach (pay_q[i]) begin
      buf_q.push_back(pay_q[i]);
      c = c ^ {24'd0, pay_q[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ crcfc_pkg::CRC_POLY) : (c >> 1);
    end
    c = ~c;
    buf_q.push_back(c[31:24]);
    buf_q.push_back(c[23:16]);
    buf_q.push_back(c[15:8]);
    buf_q.push_back(c[7:0]);
  endtask

  initial begin
    buf_kind_t kind;
    int        pct;
    int        len;
    int        idx;
    bit        hold_done;
    hold_done = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest good frame, with an all-ones payload byte.
    pay_q = '{8'hFF};
    wrap_payload(crcfc_pkg::FRAME_HEADER, 16'd1);
    send_buffer();
    // Final byte falls inside the payload window: payload result, then a too-short status.
    buf_q = '{8'h00, 8'h00, 8'h05, 8'h00};
    send_buffer();
    // Single-byte buffer.
    buf_q = '{8'hFF};
    send_buffer();
    // Bad header with the largest length; the payload still goes out.
    buf_q = '{8'h80, 8'hFF, 8'hFF, 8'h7F, 8'h01, 8'h02, 8'h04, 8'h08};
    send_buffer();
    // Zero length with enough bytes to pass the size check.
    buf_q = '{8'h00, 8'h00, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h55};
    send_buffer();

    // Random buffers, mostly well formed.
    while (bytes_sent < RANDOM_BYTES) begin
      calm = (bytes_sent >= 800) && (bytes_sent < 1100);
      if (!hold_done && bytes_sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pct = $urandom_range(99);
      if (pct < 60)      kind = BUF_GOOD;
      else if (pct < 70) kind = BUF_BAD_CRC;
      else if (pct < 76) kind = BUF_BAD_HEADER;
      else if (pct < 80) kind = BUF_ZERO_LEN;
      else if (pct < 88) kind = BUF_LEN_OFF;
      else if (pct < 94) kind = BUF_SHORT;
      else               kind = BUF_NOISE;

      pct = $urandom_range(99);
      if (pct < 85)      len = $urandom_range(12, 1);
      else if (pct < 97) len = $urandom_range(64, 13);
      else               len = $urandom_range(300, 200);
      pay_q.delete();
      random_bytes(pay_q, len);
      wrap_payload(crcfc_pkg::FRAME_HEADER, 16'(len));

      case (kind)
        BUF_BAD_CRC: begin
          // One flipped bit anywhere in the payload or the CRC.
          idx = $urandom_range(buf_q.size() - 1, 3);
          buf_q[idx] = buf_q[idx] ^ (8'd1 << $urandom_range(7));
        end
        BUF_BAD_HEADER: buf_q[0] = 8'($urandom_range(255, 1));
        BUF_ZERO_LEN: begin
          buf_q = '{crcfc_pkg::FRAME_HEADER, 8'h00, 8'h00};
          random_bytes(buf_q, $urandom_range(8, 1));
        end
        BUF_LEN_OFF: begin
          if ($urandom_range(1) == 0) repeat ($urandom_range(3, 1)) void'(buf_q.pop_back());
          else random_bytes(buf_q, $urandom_range(3, 1));
        end
        BUF_SHORT: begin
          buf_q.delete();
          random_bytes(buf_q, $urandom_range(7, 1));
        end
        BUF_NOISE: begin
          buf_q.delete();
          random_bytes(buf_q, $urandom_range(30, 8));
        end
        default: ;
      endcase
      send_buffer();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give late results a chance to show up.
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Run covered %0d buffers and %0d bytes, with one long result-side stall.",
             buffers_sent, bytes_sent);
    $display("%0d results checked, %0d buffers passed every frame check, %0d mismatches.",
             results_seen, frames_ok, fail_count);
    if (fail_count == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
